// ===== rtl/pipt_pkg.sv =====
// shared types, constants and a helper function for the point-in-polygon unit
// no dependencies; imported by pipt_cell, point_in_polygon_test_unit and the dv checker and testbench
package pipt_pkg;

  localparam int unsigned NUM_CELLS = 64;
  localparam int unsigned IDX_W     = $clog2(NUM_CELLS);
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned PROD_W    = 2 * DIFF_W;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // query token handed from cell to cell
  typedef struct packed {
    logic                     valid;
    logic                     parity;
    logic                     pend;
    logic                     dy_pos;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [PROD_W-1:0]  lhs;
    logic signed [PROD_W-1:0]  rhs;
  } token_t;

  // resolve the crossing compare left pending by the previous cell
  function automatic logic cross_hit(token_t t);
    logic hit;
    if (t.dy_pos) begin
      hit = t.lhs < t.rhs;
    end else begin
      hit = t.rhs < t.lhs;
    end
    return t.pend & hit;
  endfunction

endpackage

// ===== rtl/pipt_cell.sv =====
// one chain cell: holds one polygon corner and tests its edge against a passing query
// depends on pipt_pkg
module pipt_cell
  import pipt_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [IDX_W-1:0]          idx_i,
  input  logic [CNT_W-1:0]          count_i,
  input  logic                      adv_i,
  input  logic                      wr_en_i,
  input  logic [IDX_W-1:0]          wr_idx_i,
  input  logic signed [COORD_W-1:0] wr_x_i,
  input  logic signed [COORD_W-1:0] wr_y_i,
  input  logic signed [COORD_W-1:0] next_x_i,
  input  logic signed [COORD_W-1:0] next_y_i,
  input  logic signed [COORD_W-1:0] first_x_i,
  input  logic signed [COORD_W-1:0] first_y_i,
  output logic signed [COORD_W-1:0] vx_o,
  output logic signed [COORD_W-1:0] vy_o,
  input  token_t                    tok_i,
  output token_t                    tok_o
);

  logic signed [COORD_W-1:0] vx_q, vy_q;
  logic signed [COORD_W-1:0] ex, ey;
  logic signed [DIFF_W-1:0]  dx, dy, ax, by;
  logic                      active, last, straddle;
  token_t                    tok_d, tok_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == idx_i)) begin
      vx_q <= wr_x_i;
      vy_q <= wr_y_i;
    end
  end

  assign vx_o = vx_q;
  assign vy_o = vy_q;

  always_comb begin
    active   = {1'b0, idx_i} < count_i;
    last     = ({1'b0, idx_i} + CNT_W'(1)) == count_i;
    ex       = last ? first_x_i : next_x_i;
    ey       = last ? first_y_i : next_y_i;
    dx       = {ex[COORD_W-1], ex} - {vx_q[COORD_W-1], vx_q};
    dy       = {ey[COORD_W-1], ey} - {vy_q[COORD_W-1], vy_q};
    ax       = {tok_i.px[COORD_W-1], tok_i.px} - {vx_q[COORD_W-1], vx_q};
    by       = {tok_i.py[COORD_W-1], tok_i.py} - {vy_q[COORD_W-1], vy_q};
    straddle = (vy_q >= tok_i.py) != (ey >= tok_i.py);

    tok_d        = tok_i;
    tok_d.parity = tok_i.parity ^ cross_hit(tok_i);
    tok_d.pend   = active & straddle;
    tok_d.dy_pos = ~dy[DIFF_W-1];
    tok_d.lhs    = ax * dy;
    tok_d.rhs    = dx * by;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/point_in_polygon_test_unit.sv =====
// top level of the point-in-polygon unit: config register, cell chain, result register
// depends on pipt_pkg and pipt_cell
// a query's accepting edge loads the first of the 64 cell stages, and the result register
// follows the last; the chain holds while a stalled result waits, and the input stalls
// until the result is registered, so no new query or write is accepted while one is in flight
// reset clears the vertex count, the chain tokens and the result valid; corners are not cleared
module point_in_polygon_test_unit
  import pipt_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CNT_W-1:0]          cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      op_i,
  input  logic [IDX_W-1:0]          vertex_index_i,
  input  logic signed [COORD_W-1:0] vertex_x_i,
  input  logic signed [COORD_W-1:0] vertex_y_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      inside_res_o
);

  logic [CNT_W-1:0]          count_q, count_sat;
  logic                      busy_q, busy_d;
  logic                      out_valid_q, out_valid_d;
  logic                      inside_q, inside_d;
  logic                      in_acc, wr_en, adv, take;
  logic signed [COORD_W-1:0] vx [NUM_CELLS];
  logic signed [COORD_W-1:0] vy [NUM_CELLS];
  token_t                    tok [NUM_CELLS+1];

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i & ~busy_q;
  assign wr_en      = in_acc & (op_e'(op_i) == OP_WRITE);
  assign count_sat  = (count_q > CNT_W'(NUM_CELLS)) ? CNT_W'(NUM_CELLS) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // query token entering the first cell
  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = in_acc & (op_e'(op_i) == OP_QUERY);
    tok[0].px     = point_x_i;
    tok[0].py     = point_y_i;
  end

  assign take = tok[NUM_CELLS].valid & (~out_valid_q | ~out_stall_i);
  assign adv  = ~(tok[NUM_CELLS].valid & out_valid_q & out_stall_i);

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    pipt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (IDX_W'(g)),
      .count_i   (count_sat),
      .adv_i     (adv),
      .wr_en_i   (wr_en),
      .wr_idx_i  (vertex_index_i),
      .wr_x_i    (vertex_x_i),
      .wr_y_i    (vertex_y_i),
      .next_x_i  (vx[(g + 1) % NUM_CELLS]),
      .next_y_i  (vy[(g + 1) % NUM_CELLS]),
      .first_x_i (vx[0]),
      .first_y_i (vy[0]),
      .vx_o      (vx[g]),
      .vy_o      (vy[g]),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1])
    );
  end

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    inside_d    = inside_q;
    if (tok[0].valid) begin
      busy_d = 1'b1;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      inside_d    = tok[NUM_CELLS].parity ^ cross_hit(tok[NUM_CELLS]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inside_q <= inside_d;
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

endmodule

// ===== dv/inside_result_checker.sv =====
// checker for the point-in-polygon unit: watches config, input and result channels
// keeps its own corner table and predicts each query's inside bit; depends on pipt_pkg
`timescale 1ns / 100ps

module inside_result_checker
  import pipt_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CNT_W-1:0]          cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic                      op_i,
  input  logic [IDX_W-1:0]          vertex_index_i,
  input  logic signed [COORD_W-1:0] vertex_x_i,
  input  logic signed [COORD_W-1:0] vertex_y_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic                      inside_res_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  logic [CNT_W-1:0]          corners_in_use;
  logic signed [COORD_W-1:0] corner_x [NUM_CELLS];
  logic signed [COORD_W-1:0] corner_y [NUM_CELLS];
  logic                      inside_expected_q [$];
  logic                      want;

  // even-odd ray cast to the right, exact cross-multiplied compare
  function automatic logic crossing_parity(input logic signed [COORD_W-1:0] px,
                                           input logic signed [COORD_W-1:0] py);
    int unsigned              n;
    int unsigned              j;
    logic                     parity;
    logic                     hit;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] ex;
    logic signed [DIFF_W-1:0] ey;
    logic signed [PROD_W-1:0] lhs;
    logic signed [PROD_W-1:0] rhs;
    n = (corners_in_use > NUM_CELLS) ? NUM_CELLS : corners_in_use;
    parity = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      if ((corner_y[i] >= py) != (corner_y[j] >= py)) begin
        dx  = corner_x[j] - corner_x[i];
        dy  = corner_y[j] - corner_y[i];
        ex  = px - corner_x[i];
        ey  = py - corner_y[i];
        lhs = ex * dy;
        rhs = dx * ey;
        hit = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
        parity = parity ^ hit;
      end
    end
    return parity;
  endfunction

  task automatic flag_error(input string what, input logic exp_bit, input logic got_bit);
    if (fail_count_o < 10) begin
      $display("checker: %s, expected %0d actual %0d at %0t", what, exp_bit, got_bit, $realtime);
    end
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      corners_in_use = '0;
      inside_expected_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        corners_in_use = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_WRITE) begin
          corner_x[vertex_index_i] = vertex_x_i;
          corner_y[vertex_index_i] = vertex_y_i;
        end else begin
          inside_expected_q.push_back(crossing_parity(point_x_i, point_y_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (inside_expected_q.size() == 0) begin
          flag_error("result transaction with no query pending", 1'bx, inside_res_i);
        end else begin
          want = inside_expected_q.pop_front();
          if (inside_res_i !== want) begin
            flag_error("inside_res mismatch", want, inside_res_i);
          end
        end
      end
      pending_o = inside_expected_q.size();
    end
  end

endmodule

// ===== dv/tb_point_in_polygon_test_unit.sv =====
// testbench top for point_in_polygon_test_unit: clock, reset, stimulus and verdict
// directed polygons, then random polygon phases over several vertex counts;
// depends on pipt_pkg, the unit and inside_result_checker
`timescale 1ns / 100ps

module tb_point_in_polygon_test_unit;
  import pipt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 70;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CNT_W-1:0]          cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic                      op;
  logic [IDX_W-1:0]          vertex_index;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      out_valid;
  logic                      out_stall;
  logic                      inside_res;

  int fail_count;
  int pending;
  int cycle_count;
  int hold_left;
  bit calm;
  bit hold_req;
  bit hold_done;
  int placed_x [NUM_CELLS];
  int placed_y [NUM_CELLS];

  point_in_polygon_test_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .vertex_index_i (vertex_index),
    .vertex_x_i     (vertex_x),
    .vertex_y_i     (vertex_y),
    .point_x_i      (point_x),
    .point_y_i      (point_y),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .inside_res_o   (inside_res)
  );

  inside_result_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .op_i           (op),
    .vertex_index_i (vertex_index),
    .vertex_x_i     (vertex_x),
    .vertex_y_i     (vertex_y),
    .point_x_i      (point_x),
    .point_y_i      (point_y),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .inside_res_i   (inside_res),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = !calm && ($urandom_range(99) < 30);
    end
  end

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic send_txn(input logic op_v, input int idx, input int vx, input int vy,
                          input int px, input int py);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    op           = op_v;
    vertex_index = IDX_W'(idx);
    vertex_x     = COORD_W'(vx);
    vertex_y     = COORD_W'(vy);
    point_x      = COORD_W'(px);
    point_y      = COORD_W'(py);
    in_valid     = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_corner(input int idx, input int x, input int y);
    placed_x[idx] = x;
    placed_y[idx] = y;
    send_txn(OP_WRITE, idx, x, y, pick(-32768, 32767), pick(-32768, 32767));
  endtask

  task automatic query_point(input int x, input int y);
    send_txn(OP_QUERY, pick(0, NUM_CELLS - 1), pick(-32768, 32767), pick(-32768, 32767), x, y);
  endtask

  // wait for the unit to drain before touching the register
  task automatic set_count(input int n);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = CNT_W'(n);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int counts [15];
    int n_sel;
    int n_eff;
    int span;
    int mid;
    int box_lo;
    int box_hi;
    int lo_q;
    int hi_q;
    int r;
    int q;
    int slot;

    counts       = '{3, 4, 5, 8, 16, 64, 127, 65, 0, 1, 2, 0, 100, 64, 7};
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    op           = OP_WRITE;
    vertex_index = '0;
    vertex_x     = '0;
    vertex_y     = '0;
    point_x      = '0;
    point_y      = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // no vertices in use: always outside
    query_point(0, 0);
    query_point(-32768, 32767);

    // full-range square with horizontal edges
    write_corner(0, -32768, -32768);
    write_corner(1, 32767, -32768);
    write_corner(2, 32767, 32767);
    write_corner(3, -32768, 32767);
    set_count(4);
    query_point(0, 0);
    query_point(-32768, -32768);
    query_point(32767, 32767);
    query_point(32767, 0);
    query_point(-32768, 0);
    query_point(0, -32768);
    query_point(0, 32767);
    query_point(-1, 1);

    // first three corners form a triangle
    set_count(3);
    query_point(0, 0);
    query_point(32767, 0);
    query_point(-32768, 0);

    // single vertex and single back-and-forth edge
    set_count(1);
    query_point(-32768, -32768);
    query_point(0, 0);
    set_count(2);
    query_point(0, -32768);

    for (int k = 0; k < NUM_CELLS; k++) begin
      write_corner(k, pick(-32768, 32767), pick(-32768, 32767));
    end

    for (int ph = 0; ph < 15; ph++) begin
      n_sel = (ph == 11) ? pick(3, NUM_CELLS - 1) : counts[ph];
      n_eff = (n_sel > NUM_CELLS) ? NUM_CELLS : n_sel;
      set_count(n_sel);
      calm = (ph == 4);
      r = $urandom_range(2);
      span = (r == 0) ? 32 : (r == 1) ? 2000 : 32767;
      mid = pick(-32768 + span, 32767 - span);
      box_lo = mid - span;
      box_hi = mid + span;
      lo_q = (box_lo - 8 < -32768) ? -32768 : box_lo - 8;
      hi_q = (box_hi + 8 > 32767) ? 32767 : box_hi + 8;
      for (int k = 0; k < n_eff; k++) begin
        write_corner(k, pick(box_lo, box_hi), pick(box_lo, box_hi));
      end
      if (ph == 6) begin
        hold_req = 1'b1;
      end
      for (int k = 0; k < 30; k++) begin
        r = $urandom_range(99);
        q = $urandom_range(99);
        slot = (n_eff > 0) ? pick(0, n_eff - 1) : 0;
        if (r < 10) begin
          write_corner(pick(0, NUM_CELLS - 1), pick(-32768, 32767), pick(-32768, 32767));
        end else if (r < 20 && n_eff > 0) begin
          write_corner(slot, pick(box_lo, box_hi), pick(box_lo, box_hi));
        end else if (q < 15 && n_eff > 0) begin
          query_point(pick(lo_q, hi_q), placed_y[slot]);
        end else if (q < 22 && n_eff > 0) begin
          query_point(placed_x[slot], placed_y[pick(0, n_eff - 1)]);
        end else if (q < 90) begin
          query_point(pick(lo_q, hi_q), pick(lo_q, hi_q));
        end else begin
          query_point(pick(-32768, 32767), pick(-32768, 32767));
        end
      end
      calm = 1'b0;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
